// ===== sv/lmc_pkg.sv =====
// Shared types, constants and register codes for the layer merge compositor.
package lmc_pkg;

    localparam int CW = 16;

    localparam logic [CW-1:0] Q_ONE     = 16'hFFFF;
    localparam logic [31:0]   Q_HALF_UP = 32'd32767;

    localparam int DIV_STEP_DEFAULT = 2;

    typedef enum logic [1:0] {
        MODE_UNION      = 2'd0,
        MODE_CLIP_BACK  = 2'd1,
        MODE_CLIP_LAYER = 2'd2,
        MODE_INTERSECT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_OPACITY   = 2'd0,
        REG_MODE      = 2'd1,
        REG_MASK_EN   = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CW-1:0] back_r;
        logic [CW-1:0] back_g;
        logic [CW-1:0] back_b;
        logic [CW-1:0] top_r;
        logic [CW-1:0] top_g;
        logic [CW-1:0] top_b;
        logic          last;
    } pix_t;

    typedef struct packed {
        logic                use_div;
        logic [2:0][CW-1:0]  alt;
        logic [CW-1:0]       alpha;
        logic                last;
    } side_t;

endpackage

// ===== sv/lmc_alpha.sv =====
// Effective layer alpha: top alpha times opacity, then times the mask when enabled, over four stages.
module lmc_alpha (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [15:0]        top_alpha,
    input  logic [15:0]        back_alpha,
    input  logic [15:0]        mask_value,
    input  lmc_pkg::pix_t      pix_in,
    input  logic [15:0]        opacity,
    input  logic               mask_enabled,
    output logic               out_vld,
    output logic [15:0]        la,
    output logic [15:0]        ba,
    output lmc_pkg::pix_t      pix_out
);
    import lmc_pkg::*;

    // Rounded Q0.16 product finish: (p + 32767) / 65535 with one correction step.
    function automatic logic [CW-1:0] qdiv(input logic [31:0] p);
        logic [31:0]   pr;
        logic [CW-1:0] q0;
        logic [CW:0]   r;
        pr = p + Q_HALF_UP;
        q0 = pr[31:16];
        r  = {1'b0, pr[15:0]} + {1'b0, q0};
        qdiv = (r >= {1'b0, Q_ONE}) ? q0 + 16'd1 : q0;
    endfunction

    logic [3:0]    vld_reg;
    logic [31:0]   p1_reg;
    logic [CW-1:0] la1_reg;
    logic [31:0]   p2_reg;
    logic [CW-1:0] la1_s3_reg;
    logic [CW-1:0] la_reg;
    logic [3:0][CW-1:0] ba_reg;
    logic [1:0][CW-1:0] mv_reg;
    pix_t [3:0]    pix_reg;
    logic [CW-1:0] la_next;

    always_comb
    begin
        la_next = mask_enabled ? qdiv(p2_reg) : la1_s3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg     <= 32'(top_alpha) * 32'(opacity);
            la1_reg    <= qdiv(p1_reg);
            p2_reg     <= 32'(la1_reg) * 32'(mv_reg[1]);
            la1_s3_reg <= la1_reg;
            la_reg     <= la_next;
            ba_reg     <= {ba_reg[2:0], back_alpha};
            mv_reg     <= {mv_reg[0], mask_value};
            pix_reg    <= {pix_reg[2:0], pix_in};
        end
    end

    assign out_vld = vld_reg[3];
    assign la      = la_reg;
    assign ba      = ba_reg[3];
    assign pix_out = pix_reg[3];

endmodule

// ===== sv/lmc_weight.sv =====
// Mode logic, weighted products and rounded numerators, over three stages.
module lmc_weight (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [15:0]        la,
    input  logic [15:0]        ba,
    input  lmc_pkg::pix_t      pix,
    input  lmc_pkg::mode_t     mode,
    output logic               out_vld,
    output logic [2:0][31:0]   num,
    output logic [15:0]        den,
    output lmc_pkg::side_t     side
);
    import lmc_pkg::*;

    logic [CW:0]   sum;
    logic [CW:0]   excess;
    logic          over;
    logic [CW-1:0] x;
    logic [CW-1:0] inv;
    logic [CW-1:0] ia;
    logic [CW:0]   s;
    logic          take_top;

    logic [CW-1:0] wb_next;
    logic [CW-1:0] wt_next;
    logic [CW-1:0] den_next;
    side_t         side_next;

    logic [2:0]          vld_reg;
    logic [CW-1:0]       wb_reg;
    logic [CW-1:0]       wt_reg;
    logic [2:0][CW-1:0]  back_reg;
    logic [2:0][CW-1:0]  top_reg;
    logic [2:0][CW-1:0]  den_reg;
    side_t [2:0]         side_reg;
    logic [2:0][31:0]    pb_reg;
    logic [2:0][31:0]    pt_reg;
    logic [2:0][31:0]    num_reg;
    logic [2:0][31:0]    num_next;

    always_comb
    begin
        sum    = {1'b0, la} + {1'b0, ba};
        excess = sum - {1'b0, Q_ONE};
        over   = (sum > {1'b0, Q_ONE});
        x      = over ? excess[CW-1:0] : '0;
        inv    = Q_ONE - la;
        ia     = (ba < inv) ? ba : inv;
        s      = {1'b0, ia} + {1'b0, la};

        wb_next  = '0;
        wt_next  = '0;
        den_next = '0;
        take_top = 1'b0;
        side_next.use_div = 1'b0;
        side_next.alpha   = '0;
        side_next.last    = pix.last;

        unique case (mode)
            MODE_UNION:
            begin
                wb_next  = ia;
                wt_next  = la;
                den_next = s[CW-1:0];
                side_next.use_div = (s != '0);
                side_next.alpha   = s[CW-1:0];
            end
            MODE_CLIP_BACK:
            begin
                wb_next  = ba - x;
                wt_next  = x;
                den_next = ba;
                side_next.use_div = over;
                side_next.alpha   = ba;
            end
            MODE_CLIP_LAYER:
            begin
                take_top        = (la != '0);
                side_next.alpha = la;
            end
            MODE_INTERSECT:
            begin
                take_top        = (x != '0);
                side_next.alpha = x;
            end
            default:
            begin
                take_top = 1'b0;
            end
        endcase

        side_next.alt = take_top ? {pix.top_b, pix.top_g, pix.top_r}
                                 : {pix.back_b, pix.back_g, pix.back_r};
    end

    // Numerator carries half the divisor so that the quotient rounds half up.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            num_next[c] = pb_reg[c] + pt_reg[c] + 32'(den_reg[1] >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wb_reg   <= wb_next;
            wt_reg   <= wt_next;
            back_reg <= {pix.back_b, pix.back_g, pix.back_r};
            top_reg  <= {pix.top_b, pix.top_g, pix.top_r};
            den_reg  <= {den_reg[1:0], den_next};
            side_reg <= {side_reg[1:0], side_next};
            for (int c = 0; c < 3; c++)
            begin
                pb_reg[c] <= 32'(back_reg[c]) * 32'(wb_reg);
                pt_reg[c] <= 32'(top_reg[c]) * 32'(wt_reg);
            end
            num_reg <= num_next;
        end
    end

    assign out_vld = vld_reg[2];
    assign num     = num_reg;
    assign den     = den_reg[2];
    assign side    = side_reg[2];

endmodule

// ===== sv/lmc_div.sv =====
// Pipelined restoring divider for the three colour channels, STEP quotient bits per stage.
module lmc_div #(
    parameter int STEP = lmc_pkg::DIV_STEP_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [2:0][31:0]   num,
    input  logic [15:0]        den,
    input  lmc_pkg::side_t     side_in,
    output logic               out_vld,
    output logic [2:0][15:0]   quo,
    output lmc_pkg::side_t     side_out
);
    import lmc_pkg::*;

    localparam int NSTG = CW / STEP;

    logic [NSTG-1:0]          vld_reg;
    logic [2:0][CW-1:0]       rem_reg  [NSTG];
    logic [2:0][CW-1:0]       low_reg  [NSTG];
    logic [2:0][CW-1:0]       quo_reg  [NSTG];
    logic [CW-1:0]            den_reg  [NSTG];
    side_t                    side_reg [NSTG];

    // The quotient is known to fit in CW bits, so the upper half of the
    // numerator is already below the divisor and seeds the remainder.
    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        logic [2:0][CW-1:0] rem_src;
        logic [2:0][CW-1:0] low_src;
        logic [2:0][CW-1:0] quo_src;
        logic [CW-1:0]      den_src;
        side_t              side_src;
        logic               vld_src;
        logic [2:0][CW-1:0] rem_next;
        logic [2:0][CW-1:0] low_next;
        logic [2:0][CW-1:0] quo_next;
        logic [CW:0]        trial;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_src[c] = num[c][31:16];
                    low_src[c] = num[c][15:0];
                end
                quo_src  = '0;
                den_src  = den;
                side_src = side_in;
                vld_src  = in_vld;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                rem_src  = rem_reg[k-1];
                low_src  = low_reg[k-1];
                quo_src  = quo_reg[k-1];
                den_src  = den_reg[k-1];
                side_src = side_reg[k-1];
                vld_src  = vld_reg[k-1];
            end
        end

        always_comb
        begin
            rem_next = rem_src;
            low_next = low_src;
            quo_next = quo_src;
            trial    = '0;
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < STEP; i++)
                begin
                    trial = {rem_next[c], low_next[c][CW-1]};
                    low_next[c] = {low_next[c][CW-2:0], 1'b0};
                    if (trial >= {1'b0, den_src})
                    begin
                        trial = trial - {1'b0, den_src};
                        quo_next[c] = {quo_next[c][CW-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next[c] = {quo_next[c][CW-2:0], 1'b0};
                    end
                    rem_next[c] = trial[CW-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= den_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_vld  = vld_reg[NSTG-1];
    assign quo      = quo_reg[NSTG-1];
    assign side_out = side_reg[NSTG-1];

endmodule

// ===== sv/layer_merge_compositor.sv =====
// Top level of the layer merge compositor: configuration registers, pipeline and output register.
//
// Merges one layer pixel over one backdrop pixel per clock unless the output stalls.
// A new item can be taken in every cycle that is not stalled; each item passes
// through the alpha stages, the weight stages, the restoring divider and the output
// register; the divider resolves DIV_STEP quotient bits per stage for the union and
// clip-to-backdrop colour mix. The whole pipeline advances together and holds
// only while the output register is full and stalled; in_stall is then high.
// DIV_STEP must divide 16. Write configuration only while no item is in flight.
module layer_merge_compositor #(
    parameter int DIV_STEP = lmc_pkg::DIV_STEP_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] back_red,
    input  logic [15:0] back_green,
    input  logic [15:0] back_blue,
    input  logic [15:0] back_alpha,
    input  logic [15:0] top_red,
    input  logic [15:0] top_green,
    input  logic [15:0] top_blue,
    input  logic [15:0] top_alpha,
    input  logic [15:0] mask_value,
    input  logic        run_end,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result_red,
    output logic [15:0] result_green,
    output logic [15:0] result_blue,
    output logic [15:0] result_alpha,
    output logic        result_last
);
    import lmc_pkg::*;

    logic [CW-1:0] opacity_reg;
    mode_t         mode_reg;
    logic          mask_en_reg;

    logic          en;
    pix_t          pix_in;

    logic          a_vld;
    logic [CW-1:0] a_la;
    logic [CW-1:0] a_ba;
    pix_t          a_pix;

    logic               w_vld;
    logic [2:0][31:0]   w_num;
    logic [CW-1:0]      w_den;
    side_t              w_side;

    logic               d_vld;
    logic [2:0][CW-1:0] d_quo;
    side_t              d_side;

    logic               out_vld_reg;
    logic [2:0][CW-1:0] res_rgb_reg;
    logic [CW-1:0]      res_alpha_reg;
    logic               res_last_reg;
    logic [2:0][CW-1:0] res_rgb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= Q_ONE;
            mode_reg    <= MODE_UNION;
            mask_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_OPACITY: opacity_reg <= cfg_data;
                REG_MODE:    mode_reg    <= mode_t'(cfg_data[1:0]);
                REG_MASK_EN: mask_en_reg <= cfg_data[0];
                default:     mask_en_reg <= mask_en_reg;
            endcase
        end
    end

    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    assign pix_in = '{back_r: back_red, back_g: back_green, back_b: back_blue,
                      top_r: top_red, top_g: top_green, top_b: top_blue,
                      last: run_end};

    lmc_alpha u_alpha (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (in_valid),
        .top_alpha    (top_alpha),
        .back_alpha   (back_alpha),
        .mask_value   (mask_value),
        .pix_in       (pix_in),
        .opacity      (opacity_reg),
        .mask_enabled (mask_en_reg),
        .out_vld      (a_vld),
        .la           (a_la),
        .ba           (a_ba),
        .pix_out      (a_pix)
    );

    lmc_weight u_weight (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (a_vld),
        .la      (a_la),
        .ba      (a_ba),
        .pix     (a_pix),
        .mode    (mode_reg),
        .out_vld (w_vld),
        .num     (w_num),
        .den     (w_den),
        .side    (w_side)
    );

    lmc_div #(
        .STEP (DIV_STEP)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (w_vld),
        .num      (w_num),
        .den      (w_den),
        .side_in  (w_side),
        .out_vld  (d_vld),
        .quo      (d_quo),
        .side_out (d_side)
    );

    always_comb
    begin
        res_rgb_next = d_side.use_div ? d_quo : d_side.alt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_rgb_reg   <= res_rgb_next;
            res_alpha_reg <= d_side.alpha;
            res_last_reg  <= d_side.last;
        end
    end

    assign out_valid    = out_vld_reg;
    assign result_red   = res_rgb_reg[0];
    assign result_green = res_rgb_reg[1];
    assign result_blue  = res_rgb_reg[2];
    assign result_alpha = res_alpha_reg;
    assign result_last  = res_last_reg;

endmodule

// ===== sv/lmc_check.sv =====
// Port-level checks for the layer merge compositor and their bind to the top level.
module lmc_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] result_red,
    input logic [15:0] result_green,
    input logic [15:0] result_blue,
    input logic [15:0] result_alpha,
    input logic        result_last
);

    // A stalled result item stays put with all of its fields.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_red)
            && $stable(result_green) && $stable(result_blue)
            && $stable(result_alpha) && $stable(result_last))
        else $error("stalled result item changed");

    // The input side only waits when a finished item is blocked at the output.
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked output item");

    // The input side is never left waiting once the output drains.
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> !in_stall)
        else $error("input stalled while the output item was taken");

    // Held reset leaves no result item behind.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n && $past(!rst_n) |-> !out_valid)
        else $error("result item present during reset");

endmodule

bind layer_merge_compositor lmc_check u_lmc_check (.*);

// ===== tb/sv/layer_merge_compositor_tb.sv =====
// Self-checking testbench for the layer merge compositor with an in-file pixel scoreboard.
`timescale 1ns / 100ps

typedef struct {
    logic [15:0] back_r;
    logic [15:0] back_g;
    logic [15:0] back_b;
    logic [15:0] back_a;
    logic [15:0] top_r;
    logic [15:0] top_g;
    logic [15:0] top_b;
    logic [15:0] top_a;
    logic [15:0] mask;
    logic        last;
} in_pix_t;

typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        last;
} out_pix_t;

class pixel_scoreboard;
    logic [15:0]     opacity;
    lmc_pkg::mode_t  mode;
    logic            mask_on;
    out_pix_t        expected_pixels[$];
    int              accepted;
    int              mismatches;

    function new();
        opacity    = lmc_pkg::Q_ONE;
        mode       = lmc_pkg::MODE_UNION;
        mask_on    = 1'b0;
        accepted   = 0;
        mismatches = 0;
    endfunction

    function void apply_config(lmc_pkg::reg_idx_t idx, logic [15:0] data);
        case (idx)
            lmc_pkg::REG_OPACITY: opacity = data;
            lmc_pkg::REG_MODE:    mode = lmc_pkg::mode_t'(data[1:0]);
            lmc_pkg::REG_MASK_EN: mask_on = data[0];
            default: ;
        endcase
    endfunction

    // Q0.16 product, rounded to nearest with halves going up.
    function logic [15:0] scale_q16(logic [15:0] a, logic [15:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b) + 64'd32767;
        return 16'(prod / 64'd65535);
    endfunction

    function logic [15:0] mix_weighted(logic [15:0] b, logic [15:0] wb,
                                       logic [15:0] t, logic [15:0] wt);
        logic [63:0] den;
        logic [63:0] num;
        den = 64'(wb) + 64'(wt);
        num = 64'(b) * 64'(wb) + 64'(t) * 64'(wt) + den / 2;
        num = num / den;
        return (num > 64'd65535) ? 16'hFFFF : num[15:0];
    endfunction

    function out_pix_t composite(in_pix_t p);
        logic [15:0] la;
        logic [15:0] wb;
        logic [15:0] over;
        logic [16:0] sum;
        out_pix_t    r;
        la = scale_q16(p.top_a, opacity);
        if (mask_on)
            la = scale_q16(la, p.mask);
        r.red   = p.back_r;
        r.green = p.back_g;
        r.blue  = p.back_b;
        r.last  = p.last;
        sum = 17'(la) + 17'(p.back_a);
        over = (sum > 17'h0FFFF) ? 16'(sum - 17'h0FFFF) : 16'h0000;
        case (mode)
            lmc_pkg::MODE_UNION: begin
                // The backdrop only gets the coverage the layer leaves free.
                wb = (p.back_a < lmc_pkg::Q_ONE - la) ? p.back_a : lmc_pkg::Q_ONE - la;
                sum = 17'(wb) + 17'(la);
                if (sum != 0) begin
                    r.red   = mix_weighted(p.back_r, wb, p.top_r, la);
                    r.green = mix_weighted(p.back_g, wb, p.top_g, la);
                    r.blue  = mix_weighted(p.back_b, wb, p.top_b, la);
                end
                r.alpha = 16'(sum);
            end
            lmc_pkg::MODE_CLIP_BACK: begin
                if (over != 0) begin
                    r.red   = mix_weighted(p.back_r, p.back_a - over, p.top_r, over);
                    r.green = mix_weighted(p.back_g, p.back_a - over, p.top_g, over);
                    r.blue  = mix_weighted(p.back_b, p.back_a - over, p.top_b, over);
                end
                r.alpha = p.back_a;
            end
            lmc_pkg::MODE_CLIP_LAYER: begin
                if (la != 0) begin
                    r.red   = p.top_r;
                    r.green = p.top_g;
                    r.blue  = p.top_b;
                end
                r.alpha = la;
            end
            default: begin
                if (over != 0) begin
                    r.red   = p.top_r;
                    r.green = p.top_g;
                    r.blue  = p.top_b;
                end
                r.alpha = over;
            end
        endcase
        return r;
    endfunction

    function void note_input(in_pix_t p);
        expected_pixels.push_back(composite(p));
        accepted++;
    endfunction

    function int outstanding();
        return expected_pixels.size();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(out_pix_t got);
        out_pix_t want;
        if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d last %0b",
                     $time, got.red, got.green, got.blue, got.alpha, got.last);
            mismatches++;
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("red", want.red, got.red);
        compare_field("green", want.green, got.green);
        compare_field("blue", want.blue, got.blue);
        compare_field("alpha", want.alpha, got.alpha);
        compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
endclass

module layer_merge_compositor_tb;
    import lmc_pkg::*;

    localparam int LATENCY       = 16;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_ITEMS   = 48;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] back_red;
    logic [15:0] back_green;
    logic [15:0] back_blue;
    logic [15:0] back_alpha;
    logic [15:0] top_red;
    logic [15:0] top_green;
    logic [15:0] top_blue;
    logic [15:0] top_alpha;
    logic [15:0] mask_value;
    logic        run_end;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] result_red;
    logic [15:0] result_green;
    logic [15:0] result_blue;
    logic [15:0] result_alpha;
    logic        result_last;

    pixel_scoreboard board = new();
    out_pix_t        seen;
    in_pix_t         directed[6];
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_cycles = 0;

    layer_merge_compositor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .back_red     (back_red),
        .back_green   (back_green),
        .back_blue    (back_blue),
        .back_alpha   (back_alpha),
        .top_red      (top_red),
        .top_green    (top_green),
        .top_blue     (top_blue),
        .top_alpha    (top_alpha),
        .mask_value   (mask_value),
        .run_end      (run_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_red   (result_red),
        .result_green (result_green),
        .result_blue  (result_blue),
        .result_alpha (result_alpha),
        .result_last  (result_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Output side: random stalls, or a long hold-off while hold_cycles runs down.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.red   = result_red;
            seen.green = result_green;
            seen.blue  = result_blue;
            seen.alpha = result_alpha;
            seen.last  = result_last;
            board.check_result(seen);
        end
    end

    function automatic in_pix_t mk_pixel(logic [15:0] br, logic [15:0] bg, logic [15:0] bb,
                                         logic [15:0] ba, logic [15:0] tr, logic [15:0] tg,
                                         logic [15:0] tb, logic [15:0] ta, logic [15:0] mv,
                                         logic last);
        in_pix_t p;
        p.back_r = br;
        p.back_g = bg;
        p.back_b = bb;
        p.back_a = ba;
        p.top_r  = tr;
        p.top_g  = tg;
        p.top_b  = tb;
        p.top_a  = ta;
        p.mask   = mv;
        p.last   = last;
        return p;
    endfunction

    // Biased toward the ends of the Q0.16 range, where most corner cases live.
    function automatic logic [15:0] rand_q16();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            3: return 16'hFFFF - 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_pix_t random_pixel();
        in_pix_t p;
        p = mk_pixel(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                     rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                     $urandom_range(7) == 0);
        // Put the summed alphas right around full coverage now and then.
        if ($urandom_range(3) == 0)
            p.back_a = 16'hFFFF - p.top_a + 16'($urandom_range(3));
        return p;
    endfunction

    task automatic send_pixel(in_pix_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        back_red   <= p.back_r;
        back_green <= p.back_g;
        back_blue  <= p.back_b;
        back_alpha <= p.back_a;
        top_red    <= p.top_r;
        top_green  <= p.top_g;
        top_blue   <= p.top_b;
        top_alpha  <= p.top_a;
        mask_value <= p.mask;
        run_end    <= p.last;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(p);
        @(negedge clk);
    endtask

    task automatic finish_burst();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.outstanding() != 0)
            @(negedge clk);
    endtask

    // Leaves cfg_write high; set_config lowers it after the last write.
    task automatic write_reg(reg_idx_t idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        board.apply_config(idx, data);
    endtask

    task automatic set_config(logic [15:0] opacity, mode_t mode, logic mask_on);
        write_reg(REG_OPACITY, opacity);
        write_reg(REG_MODE, {14'($urandom), mode});
        write_reg(REG_MASK_EN, {15'($urandom), mask_on});
        if ($urandom_range(2) == 0)
            write_reg(REG_UNUSED, 16'($urandom));
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] opacity;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_OPACITY;
        cfg_data   = 16'h0000;
        in_valid   = 1'b0;
        back_red   = 16'h0000;
        back_green = 16'h0000;
        back_blue  = 16'h0000;
        back_alpha = 16'h0000;
        top_red    = 16'h0000;
        top_green  = 16'h0000;
        top_blue   = 16'h0000;
        top_alpha  = 16'h0000;
        mask_value = 16'h0000;
        run_end    = 1'b0;

        // Nothing covered at all, full layer over full backdrop, empty backdrop,
        // empty layer, a barely covered backdrop, and a partial overlap.
        directed[0] = mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        directed[1] = mk_pixel(16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, 16'hFFFF,
                               16'hFFFF, 1'b1);
        directed[2] = mk_pixel(1234, 40000, 16'hFFFF, 0, 16'hFFFF, 1, 30000, 16'hFFFF,
                               16'h8000, 1'b0);
        directed[3] = mk_pixel(5000, 6000, 7000, 16'hFFFF, 50000, 60000, 100, 0, 0, 1'b0);
        directed[4] = mk_pixel(65000, 100, 32768, 1, 10, 65535, 0, 16'hFFFF, 16'hFFFF, 1'b0);
        directed[5] = mk_pixel(20000, 45000, 0, 40000, 60000, 1000, 16'hFFFF, 30000,
                               16'hFFFF, 1'b1);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        for (int m = 0; m < 4; m++)
        begin
            // The first pass runs on the reset settings.
            case (m)
                1: set_config(16'hFFFF, MODE_CLIP_BACK, 1'b0);
                2: set_config(16'h8000, MODE_CLIP_LAYER, 1'b1);
                3: set_config(16'hFFFF, MODE_INTERSECT, 1'b1);
                default: ;
            endcase
            foreach (directed[i])
                send_pixel(directed[i]);
            finish_burst();
        end

        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            if (k < 8)
            begin
                send_idle_pct = 8;
                recv_idle_pct = 87;
            end
            else if (k < 16)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ((k + k / 4) % 5)
                0: opacity = 16'h0000;
                1: opacity = 16'hFFFF;
                2: opacity = 16'h0001;
                3: opacity = 16'h8000;
                default: opacity = 16'($urandom);
            endcase
            set_config(opacity, mode_t'(k % 4), (k / 4) % 2 == 1);
            if (k == 20)
            begin
                // Hold the output long enough for the pipeline to back up into the input.
                @(posedge clk);
                hold_cycles = 120;
                @(negedge clk);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_pixel(random_pixel());
            finish_burst();
        end

        repeat (LATENCY + 4) @(negedge clk);

        $display("Merged %0d pixels in all four modes, mask on and off, opacity from 0 to 1.0,",
                 board.accepted);
        $display("with random stalls on both sides and one long output hold-off.");
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
